// ----- rtl/insertion_candidate_top_k_selector_unit_macros.svh -----
// Assertion macros used by the checker file of the top-K insertion selector.
// Holds only macro definitions; it depends on nothing else.
`ifndef INSERTION_CANDIDATE_TOP_K_SELECTOR_UNIT_MACROS_SVH
`define INSERTION_CANDIDATE_TOP_K_SELECTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ICTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Selector check failed in the same cycle.");

// Next-cycle implication, disabled while reset is high.
`define ICTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Selector check failed in the following cycle.");

`endif

// ----- rtl/icts_pkg.sv -----
// Package of the top-K insertion selector: default sizes, the rank width, the shared
// control type and the byte padding helper. Depends on nothing.
package icts_pkg;

   // Default sizes for the top level parameters.
   localparam int KEEP_COUNT_DEF = 4;
   localparam int NODE_BITS_DEF  = 10;
   localparam int COST_BITS_DEF  = 32;

   // Width of the rank field of a result.
   localparam int RANK_BITS = 4;

   // Control bits of one candidate on its way into the list stage.
   typedef struct packed {
      logic valid;
      logic skip;
      logic last;
   } icts_item_ctrl_type;

   // Rounds a bit count up to whole bytes.
   function automatic int pad_bytes(input int bits);
      return ((bits + 7) >> 3) << 3;
   endfunction

endpackage

// ----- rtl/icts_insert.sv -----
// List stage of the top-K insertion selector: keeps the sorted list and
// inserts one candidate per cycle. Depends on icts_pkg.
module icts_insert #(
   parameter int KEEP_COUNT = icts_pkg::KEEP_COUNT_DEF,
   parameter int NODE_BITS  = icts_pkg::NODE_BITS_DEF,
   parameter int SUM_BITS   = icts_pkg::COST_BITS_DEF + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  icts_pkg::icts_item_ctrl_type  item_ctrl,
   input  logic [SUM_BITS-1:0]           item_sum,
   input  logic [NODE_BITS-1:0]          item_node,
   output logic                          dump,
   output logic [SUM_BITS-1:0]           snap_cost  [KEEP_COUNT],
   output logic [NODE_BITS-1:0]          snap_node  [KEEP_COUNT],
   output logic                          snap_valid [KEEP_COUNT]
);

   logic [SUM_BITS-1:0]  kept_cost_ff  [KEEP_COUNT];
   logic [NODE_BITS-1:0] kept_node_ff  [KEEP_COUNT];
   logic                 kept_valid_ff [KEEP_COUNT];
   logic [SUM_BITS-1:0]  kept_cost_in  [KEEP_COUNT];
   logic [NODE_BITS-1:0] kept_node_in  [KEEP_COUNT];
   logic                 kept_valid_in [KEEP_COUNT];
   logic                 stays         [KEEP_COUNT];
   logic                 take;

   // An entry stays where it is when it is filled and not above the new sum.
   // Sorted order makes these flags a prefix, so ties keep arrival order.
   always_comb begin
      for (int i = 0; i < KEEP_COUNT; i++) begin
         stays[i] = kept_valid_ff[i] && (kept_cost_ff[i] <= item_sum);
      end
   end

   assign take = item_ctrl.valid && !item_ctrl.skip;

   // Each slot keeps its entry, takes the new candidate, or takes its upper neighbor.
   for (genvar g = 0; g < KEEP_COUNT; g++) begin : g_slot
      if (g == 0) begin : g_head
         always_comb begin
            if (!take || stays[g]) begin
               snap_cost[g]  = kept_cost_ff[g];
               snap_node[g]  = kept_node_ff[g];
               snap_valid[g] = kept_valid_ff[g];
            end else begin
               snap_cost[g]  = item_sum;
               snap_node[g]  = item_node;
               snap_valid[g] = 1'b1;
            end
         end
      end else begin : g_body
         always_comb begin
            priority if (!take || stays[g]) begin
               snap_cost[g]  = kept_cost_ff[g];
               snap_node[g]  = kept_node_ff[g];
               snap_valid[g] = kept_valid_ff[g];
            end else if (stays[g-1]) begin
               snap_cost[g]  = item_sum;
               snap_node[g]  = item_node;
               snap_valid[g] = 1'b1;
            end else begin
               snap_cost[g]  = kept_cost_ff[g-1];
               snap_node[g]  = kept_node_ff[g-1];
               snap_valid[g] = kept_valid_ff[g-1];
            end
         end
      end
   end

   // The last candidate hands the updated list to the emitter.
   assign dump = item_ctrl.valid && item_ctrl.last;

   // After a dump the list starts empty again.
   always_comb begin
      for (int i = 0; i < KEEP_COUNT; i++) begin
         if (dump) begin
            kept_cost_in[i]  = '1;
            kept_node_in[i]  = '0;
            kept_valid_in[i] = 1'b0;
         end else begin
            kept_cost_in[i]  = snap_cost[i];
            kept_node_in[i]  = snap_node[i];
            kept_valid_in[i] = snap_valid[i];
         end
      end
   end

   // List registers; reset empties the list.
   always_ff @(posedge clock) begin
      for (int i = 0; i < KEEP_COUNT; i++) begin
         if (reset) begin
            kept_cost_ff[i]  <= '1;
            kept_node_ff[i]  <= '0;
            kept_valid_ff[i] <= 1'b0;
         end else begin
            kept_cost_ff[i]  <= kept_cost_in[i];
            kept_node_ff[i]  <= kept_node_in[i];
            kept_valid_ff[i] <= kept_valid_in[i];
         end
      end
   end

endmodule

// ----- rtl/icts_emit.sv -----
// Result stage of the top-K insertion selector: holds a copy of the finished
// list and sends it out one rank per transfer. Depends on icts_pkg.
module icts_emit #(
   parameter int KEEP_COUNT = icts_pkg::KEEP_COUNT_DEF,
   parameter int NODE_BITS  = icts_pkg::NODE_BITS_DEF,
   parameter int SUM_BITS   = icts_pkg::COST_BITS_DEF + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [SUM_BITS-1:0]           snap_cost  [KEEP_COUNT],
   input  logic [NODE_BITS-1:0]          snap_node  [KEEP_COUNT],
   input  logic                          snap_valid [KEEP_COUNT],
   input  logic                          out_ready,
   output logic                          out_valid,
   output logic [icts_pkg::RANK_BITS-1:0] out_rank,
   output logic [NODE_BITS-1:0]          out_node,
   output logic [SUM_BITS-1:0]           out_cost,
   output logic                          out_entry_valid,
   output logic                          out_final
);

   localparam int IDX_BITS = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;

   logic [SUM_BITS-1:0]  bank_cost_ff  [KEEP_COUNT];
   logic [NODE_BITS-1:0] bank_node_ff  [KEEP_COUNT];
   logic                 bank_valid_ff [KEEP_COUNT];
   logic                 active_ff;
   logic                 active_in;
   logic [IDX_BITS-1:0]  idx_ff;
   logic [IDX_BITS-1:0]  idx_in;
   logic                 fire;
   logic                 at_end;

   assign fire   = active_ff && out_ready;
   assign at_end = (idx_ff == IDX_BITS'(KEEP_COUNT - 1));

   // Rank counter: steps on each transfer and stops after the final rank.
   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      priority if (load) begin
         active_in = 1'b1;
         idx_in    = '0;
      end else if (fire) begin
         if (at_end) begin
            active_in = 1'b0;
            idx_in    = '0;
         end else begin
            idx_in = IDX_BITS'(idx_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
   end

   // Result bank, captured whole when a run ends.
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < KEEP_COUNT; i++) begin
            bank_cost_ff[i]  <= snap_cost[i];
            bank_node_ff[i]  <= snap_node[i];
            bank_valid_ff[i] <= snap_valid[i];
         end
      end
   end

   // The current rank selects its bank entry.
   assign out_valid       = active_ff;
   assign out_rank        = icts_pkg::RANK_BITS'(idx_ff);
   assign out_node        = bank_node_ff[idx_ff];
   assign out_cost        = bank_cost_ff[idx_ff];
   assign out_entry_valid = bank_valid_ff[idx_ff];
   assign out_final       = at_end;

endmodule

// ----- rtl/insertion_candidate_top_k_selector_unit.sv -----
// A last candidate passes the input register and then the result bank before the
// first result of its run is offered.
// Throughput: one candidate per cycle, as long as the input register is not held.
// A last candidate waits in the input register while the previous run's
// KEEP_COUNT results are still being delivered, one per cycle while rsp_tready is high.
// Reset (synchronous, active high) empties the list and drops pending results.
// Top level of the top-K insertion selector: input register, list stage and
// result stage. Depends on icts_pkg, icts_insert and icts_emit.
module insertion_candidate_top_k_selector_unit #(
   parameter int KEEP_COUNT = icts_pkg::KEEP_COUNT_DEF,
   parameter int NODE_BITS  = icts_pkg::NODE_BITS_DEF,
   parameter int COST_BITS  = icts_pkg::COST_BITS_DEF,
   localparam int SUM_BITS      = COST_BITS + 1,
   localparam int IN_DATA_BITS  = icts_pkg::pad_bytes(2 * COST_BITS + NODE_BITS),
   localparam int OUT_DATA_BITS =
      icts_pkg::pad_bytes(icts_pkg::RANK_BITS + NODE_BITS + SUM_BITS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // Fields from bit 0 up: leg_in_cost, leg_out_cost, node_index, zero fill.
   input  logic [IN_DATA_BITS-1:0]  req_tdata,
   // Fields from bit 0 up: skip.
   input  logic                     req_tuser,
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // Fields from bit 0 up: rank, best_node, best_cost, zero fill.
   output logic [OUT_DATA_BITS-1:0] rsp_tdata,
   // Fields from bit 0 up: entry_valid.
   output logic                     rsp_tuser,
   output logic                     rsp_tlast
);

   logic [COST_BITS-1:0]         leg_in_cost;
   logic [COST_BITS-1:0]         leg_out_cost;
   logic [NODE_BITS-1:0]         node_index;
   logic                         s1_valid_ff;
   logic                         s1_skip_ff;
   logic                         s1_last_ff;
   logic [SUM_BITS-1:0]          s1_sum_ff;
   logic [NODE_BITS-1:0]         s1_node_ff;
   logic                         s1_go;
   logic                         req_fire;
   logic                         emit_busy;
   logic                         dump;
   icts_pkg::icts_item_ctrl_type item_ctrl;
   logic [SUM_BITS-1:0]          snap_cost  [KEEP_COUNT];
   logic [NODE_BITS-1:0]         snap_node  [KEEP_COUNT];
   logic                         snap_valid [KEEP_COUNT];
   logic [icts_pkg::RANK_BITS-1:0] out_rank;
   logic [NODE_BITS-1:0]         out_node;
   logic [SUM_BITS-1:0]          out_cost;

   // Unpack the candidate fields.
   assign leg_in_cost  = req_tdata[COST_BITS-1:0];
   assign leg_out_cost = req_tdata[2*COST_BITS-1:COST_BITS];
   assign node_index   = req_tdata[2*COST_BITS+NODE_BITS-1:2*COST_BITS];

   // A held last candidate waits until the result stage has sent its run.
   assign s1_go      = s1_valid_ff && !(s1_last_ff && emit_busy);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Input register holds the exact sum of both legs.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sum_ff  <= SUM_BITS'(leg_in_cost) + SUM_BITS'(leg_out_cost);
         s1_node_ff <= node_index;
         s1_skip_ff <= req_tuser;
         s1_last_ff <= req_tlast;
      end
   end

   assign item_ctrl.valid = s1_go;
   assign item_ctrl.skip  = s1_skip_ff;
   assign item_ctrl.last  = s1_last_ff;

   icts_insert #(
      .KEEP_COUNT (KEEP_COUNT),
      .NODE_BITS  (NODE_BITS),
      .SUM_BITS   (SUM_BITS)
   ) u_insert (
      .clock      (clock),
      .reset      (reset),
      .item_ctrl  (item_ctrl),
      .item_sum   (s1_sum_ff),
      .item_node  (s1_node_ff),
      .dump       (dump),
      .snap_cost  (snap_cost),
      .snap_node  (snap_node),
      .snap_valid (snap_valid)
   );

   icts_emit #(
      .KEEP_COUNT (KEEP_COUNT),
      .NODE_BITS  (NODE_BITS),
      .SUM_BITS   (SUM_BITS)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .load            (dump),
      .snap_cost       (snap_cost),
      .snap_node       (snap_node),
      .snap_valid      (snap_valid),
      .out_ready       (rsp_tready),
      .out_valid       (emit_busy),
      .out_rank        (out_rank),
      .out_node        (out_node),
      .out_cost        (out_cost),
      .out_entry_valid (rsp_tuser),
      .out_final       (rsp_tlast)
   );

   // Pack the result fields.
   assign rsp_tvalid = emit_busy;
   assign rsp_tdata  = OUT_DATA_BITS'({out_cost, out_node, out_rank});

endmodule

// ----- rtl/icts_checker.sv -----
// Port checker of the top-K insertion selector, bound to the top level.
// Depends on icts_pkg and the selector's assertion macro header.
`include "insertion_candidate_top_k_selector_unit_macros.svh"

module icts_checker #(
   parameter int KEEP_COUNT = icts_pkg::KEEP_COUNT_DEF,
   parameter int NODE_BITS  = icts_pkg::NODE_BITS_DEF,
   parameter int COST_BITS  = icts_pkg::COST_BITS_DEF,
   localparam int SUM_BITS      = COST_BITS + 1,
   localparam int OUT_DATA_BITS =
      icts_pkg::pad_bytes(icts_pkg::RANK_BITS + NODE_BITS + SUM_BITS)
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [OUT_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tuser,
   input logic                     rsp_tlast
);

   localparam int RB = icts_pkg::RANK_BITS;

   logic [RB-1:0]       rank;
   logic [SUM_BITS-1:0] cost;
   logic                rsp_fire;

   assign rank     = rsp_tdata[RB-1:0];
   assign cost     = rsp_tdata[RB+NODE_BITS+SUM_BITS-1:RB+NODE_BITS];
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // A stalled result holds its payload.
   `ICTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // Within a run the ranks follow each other without a gap.
   `ICTS_ASSERT_NEXT(a_rank_step, clock, reset, rsp_fire && !rsp_tlast,
      rsp_tvalid && (rank == RB'($past(rank) + 1'b1)))

   // The final flag marks exactly the deepest rank.
   `ICTS_ASSERT_NOW(a_final_rank, clock, reset, rsp_tvalid,
      rsp_tlast == (rank == RB'(KEEP_COUNT - 1)))

   // An unfilled rank reports an infinite cost.
   `ICTS_ASSERT_NOW(a_empty_cost, clock, reset, rsp_tvalid && !rsp_tuser,
      cost == {SUM_BITS{1'b1}})

endmodule

bind insertion_candidate_top_k_selector_unit icts_checker #(
   .KEEP_COUNT (KEEP_COUNT),
   .NODE_BITS  (NODE_BITS),
   .COST_BITS  (COST_BITS)
) u_icts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- tb/candidate_rank_monitor.sv -----
`timescale 1ns / 1ps
// Monitor of the top-K insertion selector. It watches both stream channels,
// keeps its own ranked list to predict each result, and counts mismatches.
// Depends on icts_pkg for the default sizes and the rank width.
module candidate_rank_monitor #(
   parameter int KEEP   = icts_pkg::KEEP_COUNT_DEF,
   parameter int NODE_W = icts_pkg::NODE_BITS_DEF,
   parameter int COST_W = icts_pkg::COST_BITS_DEF,
   localparam int SUM_W = COST_W + 1,
   localparam int IN_W  = icts_pkg::pad_bytes(2 * COST_W + NODE_W),
   localparam int OUT_W = icts_pkg::pad_bytes(icts_pkg::RANK_BITS + NODE_W + SUM_W)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [IN_W-1:0]  req_tdata,
   input  logic             req_tuser,
   input  logic             req_tlast,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [OUT_W-1:0] rsp_tdata,
   input  logic             rsp_tuser,
   input  logic             rsp_tlast,
   output int               mismatch_count,
   output int               results_due
);

   localparam int RB = icts_pkg::RANK_BITS;
   localparam logic [SUM_W-1:0] NO_COST = '1;

   // One ranked result as it should leave the block.
   typedef struct packed {
      logic [RB-1:0]     rank;
      logic [NODE_W-1:0] node;
      logic [SUM_W-1:0]  cost;
      logic              filled;
      logic              final_rank;
   } ranked_result_type;

   // Kept candidates, cheapest first; filled entries form a prefix.
   logic [SUM_W-1:0]  best_cost [KEEP];
   logic [NODE_W-1:0] best_node [KEEP];
   logic              best_used [KEEP];

   ranked_result_type ranked_due[$];
   int                errors = 0;

   task automatic clear_ranking();
      for (int i = 0; i < KEEP; i++) begin
         best_cost[i] = NO_COST;
         best_node[i] = '0;
         best_used[i] = 1'b0;
      end
   endtask

   // The new sum goes behind every kept entry that is not larger, so equal sums
   // keep their arrival order; a slot past the end means the candidate is dropped.
   task automatic rank_candidate(input logic [SUM_W-1:0] sum,
                                 input logic [NODE_W-1:0] node);
      int slot;
      slot = 0;
      while (slot < KEEP && best_used[slot] && best_cost[slot] <= sum)
         slot++;
      if (slot < KEEP) begin
         for (int i = KEEP - 1; i > slot; i--) begin
            best_cost[i] = best_cost[i-1];
            best_node[i] = best_node[i-1];
            best_used[i] = best_used[i-1];
         end
         best_cost[slot] = sum;
         best_node[slot] = node;
         best_used[slot] = 1'b1;
      end
   endtask

   // Queue the whole list as results, then start a fresh query.
   task automatic release_ranking();
      ranked_result_type r;
      for (int i = 0; i < KEEP; i++) begin
         r.rank       = RB'(i);
         r.node       = best_used[i] ? best_node[i] : '0;
         r.cost       = best_used[i] ? best_cost[i] : NO_COST;
         r.filled     = best_used[i];
         r.final_rank = (i == KEEP - 1);
         ranked_due.push_back(r);
      end
      clear_ranking();
   endtask

   always @(posedge clock) begin
      logic [COST_W-1:0] leg_a;
      logic [COST_W-1:0] leg_b;
      ranked_result_type seen;
      ranked_result_type want;
      if (reset) begin
         clear_ranking();
         ranked_due.delete();
      end else begin
         // Candidate transfer: update the prediction.
         if (req_tvalid && req_tready) begin
            leg_a = req_tdata[COST_W-1:0];
            leg_b = req_tdata[2*COST_W-1:COST_W];
            if (!req_tuser)
               rank_candidate(SUM_W'(leg_a) + SUM_W'(leg_b),
                              req_tdata[2*COST_W +: NODE_W]);
            if (req_tlast)
               release_ranking();
         end
         // Result transfer: compare with the oldest expectation.
         if (rsp_tvalid && rsp_tready) begin
            seen.rank       = rsp_tdata[RB-1:0];
            seen.node       = rsp_tdata[RB +: NODE_W];
            seen.cost       = rsp_tdata[RB+NODE_W +: SUM_W];
            seen.filled     = rsp_tuser;
            seen.final_rank = rsp_tlast;
            if (ranked_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%t: unexpected result rank=%0d node=%0d cost=%h valid=%b last=%b",
                           $realtime, seen.rank, seen.node, seen.cost, seen.filled,
                           seen.final_rank);
            end else begin
               want = ranked_due.pop_front();
               if (seen !== want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%t: result mismatch, expected rank=%0d node=%0d cost=%h",
                              $realtime, want.rank, want.node, want.cost);
                     $display("   expected valid=%b last=%b", want.filled,
                              want.final_rank);
                     $display("   got rank=%0d node=%0d cost=%h valid=%b last=%b",
                              seen.rank, seen.node, seen.cost, seen.filled,
                              seen.final_rank);
                  end
               end
            end
         end
      end
      mismatch_count <= errors;
      results_due    <= ranked_due.size();
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the top-K insertion selector bench: clock, reset, candidate stimulus,
// result back-pressure and the verdict. Depends on icts_pkg, the selector RTL
// and candidate_rank_monitor.
module testbench;

   localparam int KEEP   = icts_pkg::KEEP_COUNT_DEF;
   localparam int NODE_W = icts_pkg::NODE_BITS_DEF;
   localparam int COST_W = icts_pkg::COST_BITS_DEF;
   localparam int SUM_W  = COST_W + 1;
   localparam int IN_W   = icts_pkg::pad_bytes(2 * COST_W + NODE_W);
   localparam int OUT_W  = icts_pkg::pad_bytes(icts_pkg::RANK_BITS + NODE_W + SUM_W);
   localparam int RANDOM_ITEMS = 370;
   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_CYCLES  = 300;

   localparam logic [COST_W-1:0] MAX_COST = '1;
   localparam logic [NODE_W-1:0] MAX_NODE = '1;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // Fields from bit 0 up: leg_in_cost, leg_out_cost, node_index, zero fill.
   logic [IN_W-1:0]  req_tdata = '0;
   // Fields from bit 0 up: skip.
   logic             req_tuser = 1'b0;
   logic             req_tlast = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // Fields from bit 0 up: rank, best_node, best_cost, zero fill.
   logic [OUT_W-1:0] rsp_tdata;
   // Fields from bit 0 up: entry_valid.
   logic             rsp_tuser;
   logic             rsp_tlast;

   int mismatch_count;
   int results_due;
   int items_sent = 0;
   bit burst = 1'b0;

   insertion_candidate_top_k_selector_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   candidate_rank_monitor #(
      .KEEP   (KEEP),
      .NODE_W (NODE_W),
      .COST_W (COST_W)
   ) monitor (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Offer one candidate after a random gap, or none in a burst, and hold it until its transfer.
   task automatic offer_candidate(input logic [COST_W-1:0] leg_a,
                                  input logic [COST_W-1:0] leg_b,
                                  input logic [NODE_W-1:0] node,
                                  input logic skip_it, input logic last_it);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= IN_W'({node, leg_b, leg_a});
      req_tuser  <= skip_it;
      req_tlast  <= last_it;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Small values force ties, the top band stresses the carry into the sum.
   function automatic logic [COST_W-1:0] draw_leg_cost(input int style);
      case (style)
         0: return COST_W'($urandom_range(0, 12));
         1: return COST_W'($urandom());
         default: return MAX_COST - COST_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic run_random_query();
      int len;
      int q_style;
      int style;
      len     = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
      q_style = $urandom_range(0, 2);
      burst   = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         style = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : q_style;
         offer_candidate(draw_leg_cost(style), draw_leg_cost(style),
                         NODE_W'($urandom_range(0, 1023)),
                         ($urandom_range(0, 5) == 0), (i == len - 1));
      end
   endtask

   // Candidate stimulus and verdict.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A lone zero-cost candidate leaves three ranks unfilled.
      offer_candidate('0, '0, '0, 1'b0, 1'b1);
      // A skipped last candidate still flushes an empty list.
      offer_candidate(MAX_COST, MAX_COST, MAX_NODE, 1'b1, 1'b1);
      // Largest sums, ties that keep arrival order, a candidate equal to a
      // full worst entry, and a skipped last candidate.
      offer_candidate(MAX_COST, MAX_COST, MAX_NODE, 1'b0, 1'b0);
      offer_candidate(MAX_COST, '0, 10'd1, 1'b0, 1'b0);
      offer_candidate('0, MAX_COST, 10'd2, 1'b0, 1'b0);
      offer_candidate('0, '0, 10'd3, 1'b1, 1'b0);
      offer_candidate(32'd5, 32'd5, 10'd4, 1'b0, 1'b0);
      offer_candidate(32'd10, 32'd0, 10'd5, 1'b0, 1'b0);
      offer_candidate(32'd3, 32'd7, 10'd6, 1'b0, 1'b0);
      offer_candidate(MAX_COST, '0, 10'd7, 1'b0, 1'b0);
      offer_candidate('0, '0, 10'd8, 1'b1, 1'b1);
      // Alternating bit patterns, and a last candidate that takes rank 0.
      offer_candidate(32'hAAAA_AAAA, 32'h5555_5555, 10'h2AA, 1'b0, 1'b0);
      offer_candidate(32'h5555_5555, 32'hAAAA_AAAA, 10'h155, 1'b0, 1'b0);
      offer_candidate(32'd1, 32'd0, 10'd17, 1'b0, 1'b0);
      offer_candidate(32'd0, 32'd2, 10'd18, 1'b0, 1'b0);
      offer_candidate(32'd0, 32'd0, 10'd19, 1'b0, 1'b1);

      while (items_sent < RANDOM_ITEMS)
         run_random_query();
      req_tvalid <= 1'b0;

      // Let the monitor count the results of the final transfer first.
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && results_due == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Result receiver: random pause after each transfer, calm stretches, and one
   // long hold-off so that the block backs up into its input.
   int sink_wait     = 0;
   int long_hold     = 0;
   int results_taken = 0;

   always @(posedge clock) begin
      int pause;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_wait  <= 0;
         long_hold  <= 0;
      end else if (long_hold > 0) begin
         long_hold  <= long_hold - 1;
         rsp_tready <= (long_hold == 1);
      end else if (rsp_tvalid && rsp_tready) begin
         results_taken <= results_taken + 1;
         pause = ((results_taken / 40) % 3 == 1) ? 0 : $urandom_range(0, 8);
         if (results_taken == 40) begin
            long_hold  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (pause == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            sink_wait  <= pause;
         end
      end else if (sink_wait > 0) begin
         sink_wait  <= sink_wait - 1;
         rsp_tready <= (sink_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule

// ----- insertion_candidate_top_k_selector_unit.f -----
+incdir+rtl
rtl/icts_pkg.sv
rtl/icts_insert.sv
rtl/icts_emit.sv
rtl/insertion_candidate_top_k_selector_unit.sv
rtl/icts_checker.sv
tb/candidate_rank_monitor.sv
tb/testbench.sv
